@@ hw/rtl/dhs_pkg.sv @@
package dhs_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 2048;
  localparam int ELEV_BITS_DEF      = 24;
  localparam int GRAD_W             = 27;
  localparam int ROW_LEN_W          = 12;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 32;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 12'd1024;
  localparam logic signed [31:0]   BASE_TERM_RST  = 32'sd188329597;
  localparam logic signed [31:0]   COEF_GX_RST    = -32'sd6658458;
  localparam logic signed [31:0]   COEF_GY_RST    = -32'sd6658458;
  localparam logic [31:0]          COEF_SQ_RST    = 32'd10737418;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 3'd0,
    CFG_BASE_TERM  = 3'd1,
    CFG_COEF_GX    = 3'd2,
    CFG_COEF_GY    = 3'd3,
    CFG_COEF_SQ    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     interior;
    logic                     last;
  } grad_t;

  typedef struct packed {
    logic signed [31:0] base_term;
    logic signed [31:0] coef_gx;
    logic signed [31:0] coef_gy;
    logic [31:0]        coef_sq;
  } coef_t;

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [34:0] g);
    logic signed [34:0] lim;
    lim = 35'sd67108863;
    if (g > lim) begin
      sat_grad = GRAD_W'(lim);
    end else if (g < -lim) begin
      sat_grad = GRAD_W'(-lim);
    end else begin
      sat_grad = g[GRAD_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/dhs_ram.sv @@
module dhs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/dhs_window.sv @@
module dhs_window #(
  parameter int MAX_ROW_LENGTH = dhs_pkg::MAX_ROW_LENGTH_DEF,
  parameter int ELEV_BITS      = dhs_pkg::ELEV_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dhs_pkg::ROW_LEN_W-1:0] row_length,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ELEV_BITS-1:0]   elev,
  input  logic                          frame_start,
  input  logic                          frame_end,
  output logic                          g_valid,
  input  logic                          g_ready,
  output dhs_pkg::grad_t                g_data
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int CW = $clog2(MAX_ROW_LENGTH + 2);

  logic              clr_r;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     col_r;
  logic [1:0]        row_r;
  logic [CW-1:0]     emit_r;
  logic [CW-1:0]     eff_w;

  logic              s1_v_r, s1_emit_r, s1_int_r, s1_fend_r, s1_fwd_r;
  logic [AW-1:0]     s1_col_r;
  logic signed [ELEV_BITS-1:0] s1_e_r, s1_fwd_up_r, s1_fwd_mid_r;
  logic signed [ELEV_BITS-1:0] win_r [6];
  logic              g_v_r;
  dhs_pkg::grad_t    g_r;

  logic              accept, s1_go, s2_free, s1_free;
  logic [AW-1:0]     col0, col_a;
  logic [1:0]        rs0, rs_a;
  logic [CW-1:0]     em0, col_inc;
  logic              emit_a, int_a;
  logic [AW-1:0]     col_nxt;
  logic [1:0]        row_nxt;
  logic [CW-1:0]     emit_nxt;

  logic signed [ELEV_BITS-1:0] up_rdata, mid_rdata, c_eff, f_eff;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic signed [ELEV_BITS-1:0] up_wdata, mid_wdata;
  logic signed [34:0] sa, sb, sc, sd, sf, sg, sh, si, gx_raw, gy_raw;

  always_comb begin
    if (row_length < 12'd3) begin
      eff_w = CW'(3);
    end else if (32'(row_length) > MAX_ROW_LENGTH) begin
      eff_w = CW'(MAX_ROW_LENGTH);
    end else begin
      eff_w = CW'(row_length);
    end
  end

  assign s2_free  = !g_v_r || g_ready;
  assign s1_go    = s1_v_r && (!s1_emit_r || s2_free);
  assign s1_free  = !s1_v_r || s1_go;
  assign in_ready = !clr_r && s1_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col0 = frame_start ? '0 : col_r;
    rs0  = frame_start ? 2'd0 : row_r;
    em0  = frame_start ? '0 : emit_r;
    col_a = col0;
    rs_a  = rs0;
    if (CW'(col0) >= eff_w) begin
      col_a = '0;
      rs_a  = (rs0 == 2'd2) ? rs0 : rs0 + 2'd1;
    end
    emit_a  = em0 >= eff_w + CW'(1);
    int_a   = (rs_a == 2'd2) && (col_a >= AW'(2));
    emit_nxt = emit_a ? em0 : em0 + CW'(1);
    col_inc  = CW'(col_a) + CW'(1);
    col_nxt  = col_inc[AW-1:0];
    row_nxt  = rs_a;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (rs_a == 2'd2) ? rs_a : rs_a + 2'd1;
    end
    if (frame_end) begin
      col_nxt  = '0;
      row_nxt  = 2'd0;
      emit_nxt = '0;
    end
  end

  assign c_eff = s1_fwd_r ? s1_fwd_up_r : up_rdata;
  assign f_eff = s1_fwd_r ? s1_fwd_mid_r : mid_rdata;

  assign ram_we    = clr_r || s1_go;
  assign ram_waddr = clr_r ? clr_addr_r : s1_col_r;
  assign up_wdata  = clr_r ? '0 : f_eff;
  assign mid_wdata = clr_r ? '0 : s1_e_r;

  dhs_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_ROW_LENGTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(up_wdata),
    .re(accept), .raddr(col_a), .rdata(up_rdata)
  );

  dhs_ram #(.WIDTH(ELEV_BITS), .DEPTH(MAX_ROW_LENGTH)) u_middle (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(mid_wdata),
    .re(accept), .raddr(col_a), .rdata(mid_rdata)
  );

  always_comb begin
    sa = 35'(win_r[0]);
    sb = 35'(win_r[1]);
    sc = 35'(c_eff);
    sd = 35'(win_r[2]);
    sf = 35'(f_eff);
    sg = 35'(win_r[4]);
    sh = 35'(win_r[5]);
    si = 35'(s1_e_r);
    gx_raw = (sa + (sd <<< 1) + sg) - (sc + (sf <<< 1) + si);
    gy_raw = (sa + (sb <<< 1) + sc) - (sg + (sh <<< 1) + si);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= 2'd0;
      emit_r     <= '0;
      s1_v_r     <= 1'b0;
      g_v_r      <= 1'b0;
      for (int n = 0; n < 6; n++) begin
        win_r[n] <= '0;
      end
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_ROW_LENGTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        emit_r <= emit_nxt;
      end
      if (s1_free) begin
        s1_v_r <= accept;
      end
      if (s1_go) begin
        win_r[0] <= win_r[1];
        win_r[1] <= c_eff;
        win_r[2] <= win_r[3];
        win_r[3] <= f_eff;
        win_r[4] <= win_r[5];
        win_r[5] <= s1_e_r;
      end
      if (s1_go && s1_emit_r) begin
        g_v_r <= 1'b1;
      end else if (g_ready) begin
        g_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r     <= col_a;
      s1_e_r       <= elev;
      s1_emit_r    <= emit_a;
      s1_int_r     <= int_a;
      s1_fend_r    <= frame_end;
      s1_fwd_r     <= s1_v_r && (s1_col_r == col_a);
      s1_fwd_up_r  <= f_eff;
      s1_fwd_mid_r <= s1_e_r;
    end
    if (s1_go && s1_emit_r) begin
      g_r.gx       <= dhs_pkg::sat_grad(gx_raw);
      g_r.gy       <= dhs_pkg::sat_grad(gy_raw);
      g_r.interior <= s1_int_r;
      g_r.last     <= s1_fend_r;
    end
  end

  assign g_valid = g_v_r;
  assign g_data  = g_r;

endmodule

@@ hw/rtl/dhs_shade.sv @@
module dhs_shade (
  input  logic           clk,
  input  logic           rst_n,
  input  dhs_pkg::coef_t coef,
  input  logic           g_valid,
  output logic           g_ready,
  input  dhs_pkg::grad_t g_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     shade,
  output logic           last
);

  localparam int XW = 88;
  localparam int QW = 110;
  localparam int KW = 112;
  localparam int NS = 13;

  typedef struct packed {
    logic [7:0]    k;
    logic [KW-1:0] k2x;
    logic [KW-1:0] kx;
    logic [XW-1:0] x;
    logic [QW-1:0] q;
    logic          interior;
    logic          pos;
    logic          last;
  } srch_t;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  logic signed [58:0] p1_gx_r, p1_gy_r;
  logic signed [53:0] p1_sqx_r, p1_sqy_r;
  logic               p1_int_r, p1_last_r;

  logic signed [60:0] p2_n_r;
  logic [53:0]        p2_s_r;
  logic               p2_int_r, p2_last_r;

  logic [58:0]        p3_xlo_r, p3_xhi_r;
  logic [59:0]        p3_ll_r;
  logic [58:0]        p3_lh_r;
  logic [57:0]        p3_hh_r;
  logic               p3_int_r, p3_last_r, p3_pos_r;

  srch_t              sr_r [9];
  srch_t              sr_nxt [8];
  logic [7:0]         shade_r;
  logic               last_r;

  logic [58:0]        nm;
  logic [117:0]       n2;

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign g_ready = rdy[0];
  assign nm      = p2_n_r[58:0];
  assign n2      = (118'(p3_hh_r) << 60) + (118'(p3_lh_r) << 31) + 118'(p3_ll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= (i == 0) ? g_valid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_gx_r   <= coef.coef_gx * g_data.gx;
      p1_gy_r   <= coef.coef_gy * g_data.gy;
      p1_sqx_r  <= g_data.gx * g_data.gx;
      p1_sqy_r  <= g_data.gy * g_data.gy;
      p1_int_r  <= g_data.interior;
      p1_last_r <= g_data.last;
    end
    if (rdy[1]) begin
      p2_n_r    <= 61'(coef.base_term) + 61'(p1_gx_r) + 61'(p1_gy_r);
      p2_s_r    <= 54'(p1_sqx_r) + 54'(p1_sqy_r);
      p2_int_r  <= p1_int_r;
      p2_last_r <= p1_last_r;
    end
    if (rdy[2]) begin
      p3_xlo_r  <= 59'(coef.coef_sq) * 59'(p2_s_r[26:0]);
      p3_xhi_r  <= 59'(coef.coef_sq) * 59'(p2_s_r[53:27]);
      p3_ll_r   <= 60'(nm[29:0]) * 60'(nm[29:0]);
      p3_lh_r   <= 59'(nm[29:0]) * 59'(nm[58:30]);
      p3_hh_r   <= 58'(nm[58:30]) * 58'(nm[58:30]);
      p3_pos_r  <= !p2_n_r[60] && (p2_n_r != '0);
      p3_int_r  <= p2_int_r;
      p3_last_r <= p2_last_r;
    end
    if (rdy[3]) begin
      sr_r[0].k        <= 8'd0;
      sr_r[0].k2x      <= '0;
      sr_r[0].kx       <= '0;
      sr_r[0].x        <= (XW'(p3_xhi_r) << 27) + XW'(p3_xlo_r) + (XW'(1) << 32);
      sr_r[0].q        <= n2[117:8];
      sr_r[0].interior <= p3_int_r;
      sr_r[0].pos      <= p3_pos_r;
      sr_r[0].last     <= p3_last_r;
    end
    if (rdy[NS-1]) begin
      if (!sr_r[8].interior) begin
        shade_r <= 8'd0;
      end else if (!sr_r[8].pos) begin
        shade_r <= 8'd1;
      end else begin
        shade_r <= sr_r[8].k + 8'd1;
      end
      last_r <= sr_r[8].last;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_srch
    localparam int B = 7 - j;
    logic [7:0]    t;
    logic [KW-1:0] cand;

    always_comb begin
      t    = sr_r[j].k | 8'(1 << B);
      cand = sr_r[j].k2x + (sr_r[j].kx << (B + 1)) + (KW'(sr_r[j].x) << (2 * B));
      sr_nxt[j] = sr_r[j];
      if ((t != 8'd255) && (cand <= KW'(sr_r[j].q))) begin
        sr_nxt[j].k   = t;
        sr_nxt[j].k2x = cand;
        sr_nxt[j].kx  = sr_r[j].kx + (KW'(sr_r[j].x) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[4+j]) begin
        sr_r[j+1] <= sr_nxt[j];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign shade     = shade_r;
  assign last      = last_r;

endmodule

@@ hw/rtl/dem_hillshade_3x3.sv @@
// Horn hillshade over a 3x3 elevation window. Samples stream in raster order,
// one per cycle while out_tready does not stall; each sample past the first
// row_length+1 of a frame (row_length clamped to 3..MAX_ROW_LENGTH) yields the
// shade byte of the pixel one row and one column behind it (0 on the border).
// Two line stores in block RAM and a 13-stage arithmetic pipeline set the rate
// of one transaction per clock while the output is not stalled. After reset
// in_tready stays low while the line stores are zeroed.
module dem_hillshade_3x3 #(
  parameter int MAX_ROW_LENGTH = dhs_pkg::MAX_ROW_LENGTH_DEF,
  parameter int ELEV_BITS      = dhs_pkg::ELEV_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ELEV_BITS + 7) / 8)*8-1:0]  in_tdata,   // elevation
  input  logic                                in_tuser,   // frame_start
  input  logic                                in_tlast,   // frame_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // shade
  output logic                                out_tlast   // last_result
);

  logic [dhs_pkg::ROW_LEN_W-1:0] row_length_r;
  dhs_pkg::coef_t                coef_r;
  logic                          g_valid, g_ready;
  dhs_pkg::grad_t                g_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r      <= dhs_pkg::ROW_LENGTH_RST;
      coef_r.base_term  <= dhs_pkg::BASE_TERM_RST;
      coef_r.coef_gx    <= dhs_pkg::COEF_GX_RST;
      coef_r.coef_gy    <= dhs_pkg::COEF_GY_RST;
      coef_r.coef_sq    <= dhs_pkg::COEF_SQ_RST;
    end else if (cfg_we) begin
      unique case (dhs_pkg::cfg_idx_t'(cfg_addr))
        dhs_pkg::CFG_ROW_LENGTH: row_length_r     <= cfg_wdata[dhs_pkg::ROW_LEN_W-1:0];
        dhs_pkg::CFG_BASE_TERM:  coef_r.base_term <= cfg_wdata;
        dhs_pkg::CFG_COEF_GX:    coef_r.coef_gx   <= cfg_wdata;
        dhs_pkg::CFG_COEF_GY:    coef_r.coef_gy   <= cfg_wdata;
        dhs_pkg::CFG_COEF_SQ:    coef_r.coef_sq   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dhs_window #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .ELEV_BITS(ELEV_BITS)) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_length  (row_length_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .elev        (in_tdata[ELEV_BITS-1:0]),
    .frame_start (in_tuser),
    .frame_end   (in_tlast),
    .g_valid     (g_valid),
    .g_ready     (g_ready),
    .g_data      (g_data)
  );

  dhs_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .g_valid   (g_valid),
    .g_ready   (g_ready),
    .g_data    (g_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .shade     (out_tdata),
    .last      (out_tlast)
  );

endmodule

@@ tb/dem_hillshade_3x3_test.sv @@
`timescale 1ns / 100ps

module dem_hillshade_3x3_test;

  typedef struct {
    logic [23:0] elev;
    logic        fstart;
    logic        fend;
  } sample_t;

  typedef struct {
    logic [7:0] shade;
    logic       last;
  } shade_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // elevation
  logic        in_tuser;   // frame_start
  logic        in_tlast;   // frame_end
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // shade
  logic        out_tlast;  // last_result

  dem_hillshade_3x3 dut (.*);

  sample_t pending_samples[$];
  shade_t  shade_queue[$];
  int      errors = 0;
  int      stim_count = 0;
  int      idle_cycles = 0;
  logic    in_acc = 0, out_acc = 0;
  int      in_gap = 0, out_stall = 0;
  bit      burst = 0;

  // shadow state
  logic [11:0] m_row_length;
  longint      m_base, m_cgx, m_cgy;
  longint      m_csq;
  int          upper_line[dhs_pkg::MAX_ROW_LENGTH_DEF];
  int          middle_line[dhs_pkg::MAX_ROW_LENGTH_DEF];
  int          win[6];
  int          col_cnt, rows_done, samples_seen;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] horn_shade(longint gx, longint gy);
    longint       n;
    logic [127:0] x, nn, n2, lhs;
    int           k, t;
    n = m_base + m_cgx * gx + m_cgy * gy;
    if (n <= 0) return 8'd1;
    x = 128'(m_csq) * 128'(gx * gx + gy * gy) + (128'd1 << 32);
    nn = 128'(n);
    n2 = nn * nn;
    k = 0;
    for (int b = 128; b > 0; b >>= 1) begin
      t = k | b;
      if (t <= 254) begin
        lhs = x * 128'(t * t * 256);
        if (lhs <= n2) k = t;
      end
    end
    return 8'(k + 1);
  endfunction

  function automatic longint clamp_grad(longint g);
    if (g > 67108863) return 67108863;
    if (g < -67108863) return -67108863;
    return g;
  endfunction

  function automatic void clear_counts();
    col_cnt = 0;
    rows_done = 0;
    samples_seen = 0;
  endfunction

  function automatic void shade_step(logic [23:0] elev, logic fs, logic fe);
    int     w, col, e;
    longint a, b, c, d, f, g, h, gx, gy;
    bit     emit;
    shade_t r;
    w = m_row_length;
    if (w < 3) w = 3;
    if (w > dhs_pkg::MAX_ROW_LENGTH_DEF) w = dhs_pkg::MAX_ROW_LENGTH_DEF;
    e = int'(signed'(elev));
    if (fs) clear_counts();
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (rows_done < 2) rows_done++;
    end
    col = col_cnt;
    a = win[0]; b = win[1]; c = upper_line[col];
    d = win[2]; f = middle_line[col];
    g = win[4]; h = win[5];
    emit = samples_seen >= w + 1;
    r.shade = 8'd0;
    if (emit && rows_done >= 2 && col >= 2) begin
      gx = clamp_grad((a + 2 * d + g) - (c + 2 * f + e));
      gy = clamp_grad((a + 2 * b + c) - (g + 2 * h + e));
      r.shade = horn_shade(gx, gy);
    end
    win[0] = win[1];
    win[1] = upper_line[col];
    win[2] = win[3];
    win[3] = middle_line[col];
    win[4] = win[5];
    win[5] = e;
    upper_line[col] = middle_line[col];
    middle_line[col] = e;
    if (samples_seen < w + 1) samples_seen++;
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (rows_done < 2) rows_done++;
    end
    if (fe) clear_counts();
    r.last = fe;
    if (emit) shade_queue.push_back(r);
  endfunction

  // driver
  always @(negedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_tdata <= s.elev;
        in_tuser <= s.fstart;
        in_tlast <= s.fend;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 99) == 0) burst = ~burst;
        in_gap = burst ? 0 : $urandom_range(0, 19);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (out_acc) out_stall = burst ? 0 : $urandom_range(0, 19);
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    shade_t exp_r;
    in_acc <= in_tvalid && in_tready;
    out_acc <= out_tvalid && out_tready;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_tvalid && in_tready) shade_step(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (shade_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected shade: expected none, actual %0d last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          exp_r = shade_queue.pop_front();
          if (out_tdata !== exp_r.shade || out_tlast !== exp_r.last) begin
            errors++;
            $display("%0t: shade mismatch: expected %0d last %0b, actual %0d last %0b",
                     $time, exp_r.shade, exp_r.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(dhs_pkg::cfg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    case (idx)
      dhs_pkg::CFG_ROW_LENGTH: m_row_length = v[11:0];
      dhs_pkg::CFG_BASE_TERM:  m_base = longint'(signed'(v));
      dhs_pkg::CFG_COEF_GX:    m_cgx = longint'(signed'(v));
      dhs_pkg::CFG_COEF_GY:    m_cgy = longint'(signed'(v));
      dhs_pkg::CFG_COEF_SQ:    m_csq = longint'(v);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_sample(logic [23:0] elev, logic fs, logic fe);
    sample_t s;
    s.elev = elev;
    s.fstart = fs;
    s.fend = fe;
    pending_samples.push_back(s);
    stim_count++;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || shade_queue.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_elev(int mode, int col, int row, int slope);
    case (mode)
      0: return 24'(slope * col + (slope / 2 + 3) * row + $urandom_range(0, 7));
      1: return 24'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic push_frame(int w, int rows, bit with_start, bit noisy);
    int mode, slope, n;
    bit fs, fe;
    mode = $urandom_range(0, 4);
    slope = int'($urandom_range(0, 600)) - 300;
    n = w * rows;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0) && with_start;
      fe = (i == n - 1);
      if (noisy && $urandom_range(0, 29) == 0) fs = 1'b1;
      if (noisy && $urandom_range(0, 29) == 0) fe = 1'b1;
      push_sample(pick_elev(mode > 3 ? 0 : mode, i % w, i / w, slope), fs, fe);
    end
  endtask

  initial begin
    int w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = dhs_pkg::CFG_ROW_LENGTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    m_row_length = dhs_pkg::ROW_LENGTH_RST;
    m_base = dhs_pkg::BASE_TERM_RST;
    m_cgx = dhs_pkg::COEF_GX_RST;
    m_cgy = dhs_pkg::COEF_GY_RST;
    m_csq = longint'(dhs_pkg::COEF_SQ_RST);
    foreach (upper_line[i]) begin
      upper_line[i] = 0;
      middle_line[i] = 0;
    end
    foreach (win[i]) win[i] = 0;
    clear_counts();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes on a three-wide raster, warm-up frame end
    write_reg(dhs_pkg::CFG_ROW_LENGTH, 32'd3);
    for (int i = 0; i < 15; i++)
      push_sample((i % 2) ? 24'h7fffff : 24'h800000, i == 0, i == 14);
    push_sample(24'h000000, 1'b1, 1'b0);
    push_sample(24'h123456, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) push_sample(24'(i * 1000), i == 0, 1'b0);
    drain();
    // set row length 0 (clamped to 3) mid-frame, extreme coefficients
    write_reg(dhs_pkg::CFG_ROW_LENGTH, 32'd0);
    write_reg(dhs_pkg::CFG_BASE_TERM, 32'h7fffffff);
    write_reg(dhs_pkg::CFG_COEF_GX, 32'h80000000);
    write_reg(dhs_pkg::CFG_COEF_GY, 32'h7fffffff);
    write_reg(dhs_pkg::CFG_COEF_SQ, 32'h0);
    push_frame(3, 3, 1'b0, 1'b0);
    drain();

    // oversized row length, frame ends inside the warm-up
    write_reg(dhs_pkg::CFG_ROW_LENGTH, 32'd4095);
    write_reg(dhs_pkg::CFG_BASE_TERM, dhs_pkg::BASE_TERM_RST);
    write_reg(dhs_pkg::CFG_COEF_GX, dhs_pkg::COEF_GX_RST);
    write_reg(dhs_pkg::CFG_COEF_GY, dhs_pkg::COEF_GY_RST);
    write_reg(dhs_pkg::CFG_COEF_SQ, 32'hffffffff);
    push_frame(400, 1, 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) push_sample(24'($urandom), 1'b0, i == 5);
    drain();
    write_reg(dhs_pkg::CFG_ROW_LENGTH, 32'd2048);
    push_frame(3, 1, 1'b1, 1'b0);
    drain();

    while (stim_count < 1100) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      write_reg(dhs_pkg::CFG_ROW_LENGTH, 32'(w));
      if (w < 3) w = 3;
      case ($urandom_range(0, 3))
        0: begin
          write_reg(dhs_pkg::CFG_BASE_TERM, $urandom);
          write_reg(dhs_pkg::CFG_COEF_GX, $urandom);
          write_reg(dhs_pkg::CFG_COEF_GY, $urandom);
          write_reg(dhs_pkg::CFG_COEF_SQ, $urandom);
        end
        1: begin
          write_reg(dhs_pkg::CFG_BASE_TERM, $urandom_range(0, 32'h20000000));
          write_reg(dhs_pkg::CFG_COEF_GX,
                    32'(int'($urandom_range(0, 32'h1000000)) - 32'h800000));
          write_reg(dhs_pkg::CFG_COEF_GY,
                    32'(int'($urandom_range(0, 32'h1000000)) - 32'h800000));
          write_reg(dhs_pkg::CFG_COEF_SQ, $urandom_range(0, 32'h4000000));
        end
        2: begin
          write_reg(dhs_pkg::CFG_BASE_TERM, dhs_pkg::BASE_TERM_RST);
          write_reg(dhs_pkg::CFG_COEF_GX, dhs_pkg::COEF_GX_RST);
          write_reg(dhs_pkg::CFG_COEF_GY, dhs_pkg::COEF_GY_RST);
          write_reg(dhs_pkg::CFG_COEF_SQ, dhs_pkg::COEF_SQ_RST);
        end
        default: ;
      endcase
      repeat ($urandom_range(1, 2))
        push_frame(w, $urandom_range(3, 8), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 4) == 0);
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
